/* design/text_console_writer_assert.svh */
// assertion macros for the console writer checker
`ifndef TEXT_CONSOLE_WRITER_ASSERT_SVH
`define TEXT_CONSOLE_WRITER_ASSERT_SVH

// same-cycle implication
`define TCW_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tcw check failed");

// next-cycle implication
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tcw check failed");

`endif

/* design/tcw_pkg.sv */
// shared constants and types for the text console writer
package tcw_pkg;

  localparam int ROWS   = 25;
  localparam int COLS   = 80;
  localparam int CELLS  = ROWS * COLS;
  localparam int ROW_W  = $clog2(ROWS);
  localparam int COL_W  = $clog2(COLS);
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;

  localparam int IN_W  = 32;
  localparam int OUT_W = 32;

  localparam logic [1:0] ACT_PUT   = 2'd0;
  localparam logic [1:0] ACT_CLEAR = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [7:0]        NEWLINE      = 8'h0a;
  localparam logic [7:0]        RESET_ATTR   = 8'h0f;
  localparam logic [CELL_W-1:0] BLANK_CELL   = 16'h0720;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic advance;
    logic newline;
    logic home;
  } cur_cmd_t;

  typedef struct packed {
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [ADDR_W-1:0] index;
  } cur_pos_t;

  typedef struct packed {
    logic start_scroll;
    logic start_clear;
  } sweep_cmd_t;

endpackage

/* design/tcw_ram.sv */
// generic simple dual-port ram with registered read
module tcw_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* design/tcw_cursor.sv */
// cursor position tracking with row and column counters
module tcw_cursor (
  input  logic               clk,
  input  logic               rst,
  input  tcw_pkg::cur_cmd_t  cmd,
  output tcw_pkg::cur_pos_t  pos,
  output logic               wrap
);

  localparam logic [tcw_pkg::ROW_W-1:0]  LAST_ROW  = tcw_pkg::ROW_W'(tcw_pkg::ROWS - 1);
  localparam logic [tcw_pkg::COL_W-1:0]  LAST_COL  = tcw_pkg::COL_W'(tcw_pkg::COLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_BASE =
    tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
  localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A = tcw_pkg::ADDR_W'(tcw_pkg::COLS);

  tcw_pkg::cur_pos_t pos_next;

  assign wrap = (pos.row == LAST_ROW) &&
                (cmd.newline || (cmd.advance && pos.col == LAST_COL));

  always_comb begin
    pos_next = pos;
    if (cmd.home) begin
      pos_next = '0;
    end else if (cmd.newline) begin
      pos_next.col = '0;
      if (pos.row == LAST_ROW) begin
        pos_next.index = LAST_BASE;
      end else begin
        pos_next.row   = pos.row + 1'b1;
        pos_next.index = pos.index - tcw_pkg::ADDR_W'(pos.col) + COLS_A;
      end
    end else if (cmd.advance) begin
      if (pos.col == LAST_COL) begin
        pos_next.col = '0;
        if (pos.row == LAST_ROW) begin
          pos_next.index = LAST_BASE;
        end else begin
          pos_next.row   = pos.row + 1'b1;
          pos_next.index = pos.index + 1'b1;
        end
      end else begin
        pos_next.col   = pos.col + 1'b1;
        pos_next.index = pos.index + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else begin
      pos <= pos_next;
    end
  end

endmodule

/* design/tcw_sweep.sv */
// screen sweeper for clear, scroll-up and the clearing pass after reset
module tcw_sweep (
  input  logic                              clk,
  input  logic                              rst,
  input  tcw_pkg::sweep_cmd_t               cmd,
  input  logic [tcw_pkg::CELL_W-1:0]        rdata,
  output tcw_pkg::ram_req_t                 req,
  output logic                              busy
);

  localparam logic [1:0] SW_IDLE  = 2'd0;
  localparam logic [1:0] SW_COPY  = 2'd1;
  localparam logic [1:0] SW_BLANK = 2'd2;

  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_CELL = tcw_pkg::ADDR_W'(tcw_pkg::CELLS - 1);
  localparam logic [tcw_pkg::ADDR_W-1:0] LAST_BASE =
    tcw_pkg::ADDR_W'(tcw_pkg::CELLS - tcw_pkg::COLS);
  localparam logic [tcw_pkg::ADDR_W-1:0] COLS_A = tcw_pkg::ADDR_W'(tcw_pkg::COLS);

  logic [1:0]                  state;
  logic [tcw_pkg::ADDR_W-1:0]  addr;
  logic                        pend;
  logic [tcw_pkg::ADDR_W-1:0]  pend_addr;

  assign busy = (state != SW_IDLE) || pend;

  always_comb begin
    req = '0;
    if (pend) begin
      req.we    = 1'b1;
      req.waddr = pend_addr;
      req.wdata = rdata;
    end
    case (state)
      SW_COPY: begin
        req.re    = 1'b1;
        req.raddr = addr;
      end
      SW_BLANK: begin
        if (!pend) begin
          req.we    = 1'b1;
          req.waddr = addr;
          req.wdata = tcw_pkg::BLANK_CELL;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    pend_addr <= addr - COLS_A;
    if (rst) begin
      state <= SW_BLANK;
      addr  <= '0;
      pend  <= 1'b0;
    end else begin
      pend <= (state == SW_COPY);
      case (state)
        SW_IDLE: begin
          if (cmd.start_clear) begin
            state <= SW_BLANK;
            addr  <= '0;
          end else if (cmd.start_scroll) begin
            state <= SW_COPY;
            addr  <= COLS_A;
          end
        end
        SW_COPY: begin
          if (addr == LAST_CELL) begin
            state <= SW_BLANK;
            addr  <= LAST_BASE;
          end else begin
            addr <= addr + 1'b1;
          end
        end
        SW_BLANK: begin
          if (!pend) begin
            if (addr == LAST_CELL) begin
              state <= SW_IDLE;
            end else begin
              addr <= addr + 1'b1;
            end
          end
        end
        default: state <= SW_IDLE;
      endcase
    end
  end

endmodule

/* design/text_console_writer.sv */
// text console writer top level: item control, screen ram and result register
//
// The screen (25 rows of 80 cells) lives in one ram with one write and one
// registered read port. After reset the block clears the ram, one cell a
// cycle, and takes no item until the clear is done; the configuration port
// is open from the start. A put, newline or unused action goes from idle
// straight to the done state unless it scrolls; a read passes through the
// read state first, unless the index lies past the last cell. A clear walks
// every cell once. A scroll copies every row but the first up by one row
// through the ram, one cell a cycle, then blanks the last row. The next item
// is taken while a result still waits on the output register.
module text_console_writer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [7:0]                cfg_data,      // default_attr
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // action[1:0], char_code[9:2], color[17:10], read_index[28:18], zeros above
  input  logic [tcw_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // cursor_row[4:0], cursor_col[11:5], scrolled[12], read_char[20:13],
  // read_attr[28:21], zeros above
  output logic [tcw_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_SWEEP = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]  state;
  logic [7:0]  default_attr;
  logic        res_scrolled;
  logic [7:0]  res_char;
  logic [7:0]  res_attr;

  logic [1:0]  in_action;
  logic [7:0]  in_char;
  logic [7:0]  in_color;
  logic [10:0] in_index;
  logic        accept;
  logic        read_hit;
  logic        sweep_busy;
  logic        wrap;

  tcw_pkg::cur_cmd_t   cur_cmd;
  tcw_pkg::cur_pos_t   cur_pos;
  tcw_pkg::sweep_cmd_t sweep_cmd;
  tcw_pkg::ram_req_t   item_req;
  tcw_pkg::ram_req_t   sweep_req;
  tcw_pkg::ram_req_t   ram_req;
  logic [tcw_pkg::CELL_W-1:0] rdata;

  assign in_action = s_axis_tdata[1:0];
  assign in_char   = s_axis_tdata[9:2];
  assign in_color  = s_axis_tdata[17:10];
  assign in_index  = s_axis_tdata[28:18];

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (state == ST_IDLE) && !sweep_busy;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign read_hit      = (32'(in_index) < tcw_pkg::CELLS);

  always_comb begin
    cur_cmd         = '0;
    cur_cmd.advance = accept && (in_action == tcw_pkg::ACT_PUT) &&
                      (in_char != tcw_pkg::NEWLINE);
    cur_cmd.newline = accept && (in_action == tcw_pkg::ACT_PUT) &&
                      (in_char == tcw_pkg::NEWLINE);
    cur_cmd.home    = accept && (in_action == tcw_pkg::ACT_CLEAR);

    sweep_cmd.start_clear  = cur_cmd.home;
    sweep_cmd.start_scroll = wrap;

    item_req       = '0;
    item_req.we    = cur_cmd.advance;
    item_req.waddr = cur_pos.index;
    item_req.wdata = {(in_color != 8'd0) ? in_color : default_attr, in_char};
    item_req.re    = accept && (in_action == tcw_pkg::ACT_READ) && read_hit;
    item_req.raddr = tcw_pkg::ADDR_W'(in_index);

    ram_req = sweep_busy ? sweep_req : item_req;
  end

  tcw_cursor u_cursor (
    .clk  (clk),
    .rst  (rst),
    .cmd  (cur_cmd),
    .pos  (cur_pos),
    .wrap (wrap)
  );

  tcw_sweep u_sweep (
    .clk   (clk),
    .rst   (rst),
    .cmd   (sweep_cmd),
    .rdata (rdata),
    .req   (sweep_req),
    .busy  (sweep_busy)
  );

  tcw_ram #(
    .WIDTH (tcw_pkg::CELL_W),
    .DEPTH (tcw_pkg::CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      default_attr <= tcw_pkg::RESET_ATTR;
    end else if (cfg_valid && cfg_ready) begin
      default_attr <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != ST_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            res_scrolled <= wrap;
            res_char     <= 8'd0;
            res_attr     <= 8'd0;
            if (wrap || cur_cmd.home) begin
              state <= ST_SWEEP;
            end else if (item_req.re) begin
              state <= ST_READ;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        ST_READ: begin
          res_char <= rdata[7:0];
          res_attr <= rdata[15:8];
          state    <= ST_DONE;
        end
        ST_SWEEP: begin
          if (!sweep_busy) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            m_axis_tdata  <= {3'b000, res_attr, res_char, res_scrolled,
                              7'(cur_pos.col), 5'(cur_pos.row)};
            state         <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* design/tcw_checker.sv */
// port-level assertion checker for the text console writer, with its bind
`include "text_console_writer_assert.svh"

module tcw_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      s_axis_tready,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [tcw_pkg::OUT_W-1:0] m_axis_tdata
);

  // stalled result holds
  `TCW_ASSERT_NEXT(a_out_hold, clk, rst, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

  // cursor stays on the screen
  `TCW_ASSERT_NOW(a_cursor_range, clk, rst, m_axis_tvalid, (m_axis_tdata[4:0] < tcw_pkg::ROWS) && (m_axis_tdata[11:5] < tcw_pkg::COLS) && (m_axis_tdata[31:29] == 3'b000))

  // a scroll leaves the cursor on the last row and reads nothing
  `TCW_ASSERT_NOW(a_scroll_row, clk, rst, m_axis_tvalid && m_axis_tdata[12], (m_axis_tdata[4:0] == 5'(tcw_pkg::ROWS - 1)) && (m_axis_tdata[28:13] == 16'd0))

  // clearing pass after reset holds off items and results
  `TCW_ASSERT_NEXT(a_reset_clear, clk, 1'b0, rst, !s_axis_tready && !m_axis_tvalid)

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
